>>> hw/rtl/ssa_pkg.sv
// Package for the sun sensor angle estimator: widths, defaults, CORDIC table.
`default_nettype none
package ssa_pkg;
  localparam int SampleBitsDefault  = 16;
  localparam int CordicStepsDefault = 16;
  localparam int AtanTableLen       = 24;
  localparam int FieldBits          = 16;
  localparam int GainBits           = 16;
  localparam int AngleBits          = 16;
  localparam int AngleLimit         = 25736;
  localparam int GainReset          = 4096;
  localparam int CfgIndexBits       = 2;
  localparam logic [CfgIndexBits-1:0] CfgAlphaGain = 2'd0;
  localparam logic [CfgIndexBits-1:0] CfgGammaGain = 2'd1;
  localparam int ZBits              = 32;

  typedef logic signed [ZBits-1:0] z_t;

  function automatic z_t atan_q30(input int idx);
    z_t r;
    r = '0;
    unique case (idx)
      0:  r = 32'h3243F6A8;
      1:  r = 32'h1DAC6705;
      2:  r = 32'h0FADBAFC;
      3:  r = 32'h07F56EA6;
      4:  r = 32'h03FEAB76;
      5:  r = 32'h01FFD55B;
      6:  r = 32'h00FFFAAA;
      7:  r = 32'h007FFF55;
      8:  r = 32'h003FFFEA;
      9:  r = 32'h001FFFFD;
      10: r = 32'h000FFFFF;
      11: r = 32'h0007FFFF;
      12: r = 32'h0003FFFF;
      13: r = 32'h0001FFFF;
      14: r = 32'h0000FFFF;
      15: r = 32'h00007FFF;
      16: r = 32'h00003FFF;
      17: r = 32'h00001FFF;
      18: r = 32'h00000FFF;
      19: r = 32'h000007FF;
      20: r = 32'h000003FF;
      21: r = 32'h000001FF;
      22: r = 32'h000000FF;
      23: r = 32'h0000007F;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/ssa_cordic.sv
// Pipelined vectoring CORDIC: one stage per iteration, rounds and clamps the angle.
`default_nettype none
module ssa_cordic
  import ssa_pkg::*;
#(
  parameter int VW    = 60,
  parameter int STEPS = CordicStepsDefault
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic signed [VW-1:0]        x_in,
  input  wire logic signed [VW-1:0]        y_in,
  output logic                             out_valid,
  output logic signed [AngleBits-1:0]      angle
);
  localparam int NS = (STEPS < AtanTableLen) ? STEPS : AtanTableLen;

  logic                 vld [NS+1];
  logic signed [VW-1:0] xs  [NS+1];
  logic signed [VW-1:0] ys  [NS+1];
  z_t                   zs  [NS+1];
  logic                 fin_vld;
  logic signed [AngleBits-1:0] fin;

  assign vld[0] = in_valid;
  assign xs[0]  = x_in;
  assign ys[0]  = y_in;
  assign zs[0]  = '0;

  for (genvar i = 0; i < NS; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      if (!ys[i][VW-1]) begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + atan_q30(i);
      end else begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - atan_q30(i);
      end
    end
  end

  logic signed [ZBits:0] zr;
  logic signed [ZBits-16:0] zq;
  assign zr = {zs[NS][ZBits-1], zs[NS]} + (ZBits+1)'(33'sd32768);
  assign zq = zr[ZBits:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_vld <= 1'b0;
    end else begin
      fin_vld <= vld[NS];
    end
    if (zq > (ZBits-15)'(AngleLimit)) begin
      fin <= AngleBits'(AngleLimit);
    end else if (zq < -(ZBits-15)'(AngleLimit)) begin
      fin <= -AngleBits'(AngleLimit);
    end else begin
      fin <= zq[AngleBits-1:0];
    end
  end

  assign out_valid = fin_vld;
  assign angle     = fin;
endmodule
`default_nettype wire

>>> hw/rtl/sun_sensor_angle_from_six_cells_unit.sv
// Top level of the six-cell sun sensor angle estimator.
// Usage:
//   Pulse start with six samples while busy is low; busy is tied low, so one
//   item may be started every clock cycle.
//   Gains are written on the cfg channel (cfg_valid/cfg_ready, index, data);
//   index 0 alpha gain, index 1 gamma gain, others ignored. Write only when
//   the pipe is empty.
//   Each item gives one result, shown for one cycle with done high.
//   Pipeline: 4 front stages (min, subtract, sums, gain multiply) plus
//   CORDIC_STEPS iterations (at most 24) plus one rounding stage.
//   Throughput one item per cycle, set by the fully unrolled CORDIC
//   pipeline, one stage per iteration.
//   Reset clears all valid bits and sets both gains to 1.0 (4096).
//   The receiver cannot stall; results are never held.
`default_nettype none
module sun_sensor_angle_from_six_cells_unit
  import ssa_pkg::*;
#(
  parameter int SAMPLE_BITS  = SampleBitsDefault,
  parameter int CORDIC_STEPS = CordicStepsDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [FieldBits-1:0]          cell_lo_left,
  input  wire logic [FieldBits-1:0]          cell_lo_mid,
  input  wire logic [FieldBits-1:0]          cell_lo_right,
  input  wire logic [FieldBits-1:0]          cell_hi_left,
  input  wire logic [FieldBits-1:0]          cell_hi_mid,
  input  wire logic [FieldBits-1:0]          cell_hi_right,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CfgIndexBits-1:0]       cfg_index,
  input  wire logic [GainBits-1:0]           cfg_data,
  output logic                               done,
  output logic signed [AngleBits-1:0]        alpha_angle,
  output logic signed [AngleBits-1:0]        gamma_angle,
  output logic                               used_right_half,
  output logic                               invalid_ratio
);
  localparam int SB  = (SAMPLE_BITS < FieldBits) ? SAMPLE_BITS : FieldBits;
  localparam int HB  = SB + 2;            // half sum width
  localparam int VW  = HB + GainBits + 4; // CORDIC datapath width with growth
  localparam int NS  = (CORDIC_STEPS < AtanTableLen) ? CORDIC_STEPS : AtanTableLen;
  localparam int SIDE = NS + 1;           // side-band delay through CORDIC

  logic [GainBits-1:0] alpha_gain, gamma_gain;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain <= GainBits'(GainReset);
      gamma_gain <= GainBits'(GainReset);
    end else if (cfg_valid) begin
      if (cfg_index == CfgAlphaGain) alpha_gain <= cfg_data;
      if (cfg_index == CfgGammaGain) gamma_gain <= cfg_data;
    end
  end

  // stage 1: capture and minimum
  logic          v1, v2, v3, v4;
  logic [SB-1:0] c1 [6];
  logic [SB-1:0] mn1;
  logic [SB-1:0] cin [6];
  logic [SB-1:0] m01, m23, m45, m03;

  assign cin[0] = cell_lo_left[SB-1:0];
  assign cin[1] = cell_lo_mid[SB-1:0];
  assign cin[2] = cell_lo_right[SB-1:0];
  assign cin[3] = cell_hi_left[SB-1:0];
  assign cin[4] = cell_hi_mid[SB-1:0];
  assign cin[5] = cell_hi_right[SB-1:0];
  assign m01 = (cin[0] < cin[1]) ? cin[0] : cin[1];
  assign m23 = (cin[2] < cin[3]) ? cin[2] : cin[3];
  assign m45 = (cin[4] < cin[5]) ? cin[4] : cin[5];
  assign m03 = (m01 < m23) ? m01 : m23;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    c1  <= cin;
    mn1 <= (m03 < m45) ? m03 : m45;
  end

  // stage 2: subtract minimum
  logic [SB-1:0] d2 [6];
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    for (int k = 0; k < 6; k++) begin
      d2[k] <= c1[k] - mn1;
    end
  end

  // stage 3: half select and sums
  logic [SB:0]          lcol, rcol, mcol;
  logic                 right3;
  logic [HB-1:0]        half3;
  logic signed [HB:0]   outer3, rowd3;
  logic                 right_c;
  assign lcol = {1'b0, d2[0]} + {1'b0, d2[3]};
  assign rcol = {1'b0, d2[2]} + {1'b0, d2[5]};
  assign mcol = {1'b0, d2[1]} + {1'b0, d2[4]};
  assign right_c = !(lcol >= rcol);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    right3 <= right_c;
    if (!right_c) begin
      half3  <= HB'(lcol) + HB'(mcol);
      outer3 <= (HB+1)'(lcol);
      rowd3  <= (HB+1)'(d2[0]) + (HB+1)'(d2[1]) - (HB+1)'(d2[3]) - (HB+1)'(d2[4]);
    end else begin
      half3  <= HB'(rcol) + HB'(mcol);
      outer3 <= -(HB+1)'(rcol);
      rowd3  <= (HB+1)'(d2[1]) + (HB+1)'(d2[2]) - (HB+1)'(d2[4]) - (HB+1)'(d2[5]);
    end
  end

  // stage 4: gain multiply
  logic signed [VW-1:0] x4, ya4, yg4;
  logic                 right4, inv4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    x4     <= VW'({half3, 12'd0});
    ya4    <= VW'(outer3 * $signed({1'b0, alpha_gain}));
    yg4    <= VW'(rowd3 * $signed({1'b0, gamma_gain}));
    right4 <= right3;
    inv4   <= (half3 == '0);
  end

  logic va, vg;
  logic signed [AngleBits-1:0] aa, ga;

  ssa_cordic #(.VW(VW), .STEPS(CORDIC_STEPS)) u_alpha (
    .clk(clk), .rst(rst), .in_valid(v4), .x_in(x4), .y_in(ya4),
    .out_valid(va), .angle(aa)
  );
  ssa_cordic #(.VW(VW), .STEPS(CORDIC_STEPS)) u_gamma (
    .clk(clk), .rst(rst), .in_valid(v4), .x_in(x4), .y_in(yg4),
    .out_valid(vg), .angle(ga)
  );

  logic sd_right [SIDE];
  logic sd_inv   [SIDE];
  always_ff @(posedge clk) begin
    sd_right[0] <= right4;
    sd_inv[0]   <= inv4;
    for (int k = 1; k < SIDE; k++) begin
      sd_right[k] <= sd_right[k-1];
      sd_inv[k]   <= sd_inv[k-1];
    end
  end

  assign done            = va & vg;
  assign used_right_half = sd_right[SIDE-1];
  assign invalid_ratio   = sd_inv[SIDE-1];
  assign alpha_angle     = sd_inv[SIDE-1] ? '0 : aa;
  assign gamma_angle     = sd_inv[SIDE-1] ? '0 : ga;
endmodule
`default_nettype wire

>>> hw/rtl/ssa_checker.sv
// Port-level checker for the sun sensor angle estimator, bound to the top level.
`default_nettype none
module ssa_checker
  import ssa_pkg::*;
(
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          done,
  input wire logic signed [AngleBits-1:0]   alpha_angle,
  input wire logic signed [AngleBits-1:0]   gamma_angle,
  input wire logic                          invalid_ratio
);
  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && invalid_ratio |-> alpha_angle == 0 && gamma_angle == 0)
    else $error("invalid item with non-zero angle");
  a_alpha_range: assert property (@(posedge clk) disable iff (rst)
    done |-> alpha_angle <= AngleLimit && alpha_angle >= -AngleLimit)
    else $error("alpha out of range");
  a_gamma_range: assert property (@(posedge clk) disable iff (rst)
    done |-> gamma_angle <= AngleLimit && gamma_angle >= -AngleLimit)
    else $error("gamma out of range");
  a_never_busy: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("start refused");
endmodule

bind sun_sensor_angle_from_six_cells_unit ssa_checker u_ssa_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .alpha_angle(alpha_angle), .gamma_angle(gamma_angle),
  .invalid_ratio(invalid_ratio)
);
`default_nettype wire

>>> test/tb.sv
// Testbench for the six-cell sun sensor angle estimator: random and directed items, scoreboard.
`default_nettype none
import ssa_pkg::*;

typedef struct packed {
  logic signed [AngleBits-1:0] alpha;
  logic signed [AngleBits-1:0] gamma;
  logic                        right;
  logic                        invalid;
} angles_t;

class angle_board;
  angles_t pending[$];
  logic [GainBits-1:0] alpha_gain = GainBits'(GainReset);
  logic [GainBits-1:0] gamma_gain = GainBits'(GainReset);
  int errors = 0;

  static function automatic logic signed [63:0] floor_shr(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [15:0] atan_q14(logic signed [63:0] x, logic signed [63:0] y);
    logic signed [63:0] z, xs, ys;
    z = '0;
    for (int i = 0; i < CordicStepsDefault && i < AtanTableLen; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + 64'(atan_q30(i));
      end else begin
        x = x - ys; y = y + xs; z = z - 64'(atan_q30(i));
      end
    end
    z = floor_shr(z + (64'sd1 <<< 15), 16);
    if (z > 64'(AngleLimit)) z = 64'(AngleLimit);
    if (z < -64'(AngleLimit)) z = -64'(AngleLimit);
    return z[15:0];
  endfunction

  function void note_item(logic [15:0] c[6]);
    logic signed [63:0] v[6], mn, half, outer, rowdiff;
    angles_t r;
    mn = 64'(c[0]);
    for (int k = 0; k < 6; k++) begin
      v[k] = 64'(c[k]);
      if (v[k] < mn) mn = v[k];
    end
    for (int k = 0; k < 6; k++) v[k] = v[k] - mn;
    r = '0;
    r.right = !((v[0] + v[3]) >= (v[2] + v[5]));
    if (!r.right) begin
      half = v[0] + v[1] + v[3] + v[4];
      outer = v[0] + v[3];
      rowdiff = v[0] + v[1] - v[3] - v[4];
    end else begin
      half = v[1] + v[2] + v[4] + v[5];
      outer = -(v[2] + v[5]);
      rowdiff = v[1] + v[2] - v[4] - v[5];
    end
    r.invalid = (half == 0);
    if (!r.invalid) begin
      r.alpha = atan_q14(half * 4096, $signed({48'd0, alpha_gain}) * outer);
      r.gamma = atan_q14(half * 4096, $signed({48'd0, gamma_gain}) * rowdiff);
    end
    pending.push_back(r);
  endfunction

  function void check_result(angles_t got);
    angles_t w;
    if (pending.size() == 0) begin
      $display("%0t: result with nothing expected: %h", $time, got);
      errors++;
      return;
    end
    w = pending.pop_front();
    if (got.alpha !== w.alpha) begin
      $display("%0t: alpha expected %0d actual %0d", $time, w.alpha, got.alpha); errors++;
    end
    if (got.gamma !== w.gamma) begin
      $display("%0t: gamma expected %0d actual %0d", $time, w.gamma, got.gamma); errors++;
    end
    if (got.right !== w.right) begin
      $display("%0t: right half expected %0b actual %0b", $time, w.right, got.right); errors++;
    end
    if (got.invalid !== w.invalid) begin
      $display("%0t: invalid expected %0b actual %0b", $time, w.invalid, got.invalid);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int Latency = CordicStepsDefault + 5;
  localparam int CycleLimit = 200000;

  logic clk = 0, rst = 1, start = 0, cfg_valid = 0;
  logic busy, cfg_ready, done, used_right_half, invalid_ratio;
  logic [FieldBits-1:0] cell_lo_left = 0, cell_lo_mid = 0, cell_lo_right = 0;
  logic [FieldBits-1:0] cell_hi_left = 0, cell_hi_mid = 0, cell_hi_right = 0;
  logic [CfgIndexBits-1:0] cfg_index = CfgAlphaGain;
  logic [GainBits-1:0] cfg_data = 0;
  logic signed [AngleBits-1:0] alpha_angle, gamma_angle;
  angle_board board;
  int cycles = 0;
  bit quiet_end = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  sun_sensor_angle_from_six_cells_unit dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done)
      board.check_result('{alpha_angle, gamma_angle, used_right_half, invalid_ratio});
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(logic [15:0] c[6]);
    int gap;
    if (!quiet_end && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    {cell_lo_left, cell_lo_mid, cell_lo_right} <= {c[0], c[1], c[2]};
    {cell_hi_left, cell_hi_mid, cell_hi_right} <= {c[3], c[4], c[5]};
    do @(posedge clk); while (busy);
    board.note_item(c);
  endtask

  task automatic write_gain(logic [CfgIndexBits-1:0] idx, logic [GainBits-1:0] val);
    start <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (Latency + 2) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == CfgAlphaGain) board.alpha_gain = val;
    else if (idx == CfgGammaGain) board.gamma_gain = val;
  endtask

  function automatic logic [15:0] rand_cell(int mode);
    case (mode)
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(1000, 1100));
      default: return $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [15:0] c[6];
    int mode;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(0, 5);
      foreach (c[k]) c[k] = rand_cell(mode > 2 ? 0 : mode);
      if ($urandom_range(0, 19) == 0) foreach (c[k]) c[k] = c[0];
      send_item(c);
    end
  endtask

  initial begin
    logic [15:0] c[6];
    board = new();
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    c = '{0, 0, 0, 0, 0, 0}; send_item(c);
    c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}; send_item(c);
    c = '{16'hFFFF, 0, 0, 16'hFFFF, 0, 0}; send_item(c);
    c = '{0, 0, 16'hFFFF, 0, 0, 16'hFFFF}; send_item(c);
    c = '{16'hFFFF, 16'hFFFF, 0, 0, 0, 0}; send_item(c);
    c = '{0, 0, 0, 16'hFFFF, 16'hFFFF, 0}; send_item(c);
    c = '{0, 16'hFFFF, 16'hFFFF, 0, 0, 0}; send_item(c);
    c = '{0, 0, 0, 0, 16'hFFFF, 16'hFFFF}; send_item(c);
    c = '{0, 16'hFFFF, 0, 0, 16'hFFFF, 0}; send_item(c);
    c = '{5, 7, 5, 5, 7, 5}; send_item(c);
    c = '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}; send_item(c);
    c = '{1, 0, 0, 0, 0, 0}; send_item(c);
    c = '{0, 0, 1, 0, 0, 0}; send_item(c);
    random_phase(250);
    write_gain(CfgAlphaGain, 0);
    write_gain(CfgGammaGain, 16'hFFFF);
    c = '{16'hFFFF, 0, 0, 16'hFFFF, 0, 0}; send_item(c);
    c = '{0, 16'hFFFF, 0, 0, 0, 0}; send_item(c);
    random_phase(300);
    write_gain(CfgAlphaGain, 16'hFFFF);
    write_gain(CfgGammaGain, 0);
    write_gain(2'd2, 16'h1234);
    write_gain(2'd3, 16'h4321);
    c = '{16'hFFFF, 0, 0, 16'hFFFF, 0, 0}; send_item(c);
    random_phase(300);
    write_gain(CfgAlphaGain, 1);
    write_gain(CfgGammaGain, 1);
    random_phase(250);
    write_gain(CfgAlphaGain, GainBits'($urandom_range(0, 65535)));
    write_gain(CfgGammaGain, GainBits'($urandom_range(0, 65535)));
    random_phase(300);
    quiet_end = 1;
    random_phase(230);
    start <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
    if (board.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
